// ===== src/gtm_pkg.sv =====
// Shared types and constants of the Goertzel tone magnitude core.
// Used by every module under src; depends on nothing.
package gtm_pkg;

	localparam int SAMPLE_W   = 16;   // ADC sample width
	localparam int ACC_W      = 48;   // recurrence state, Q40.8
	localparam int COEF_W     = 32;   // Q2.30 / Q1.30 registers
	localparam int MAG_W      = 32;   // output magnitude
	localparam int FRAC_SHIFT = 30;   // coefficient fraction bits
	localparam int SAMPLE_FRAC = 8;   // sample enters as x * 256
	localparam int HALF_W     = ACC_W / 2;       // multiplier slice
	localparam int PROD_W     = 2 * ACC_W;       // product accumulator
	localparam int RAD_W      = 80;              // radicand bits used by the root
	localparam int ROOT_W     = RAD_W / 2;       // root bits, one per step
	localparam int REM_W      = ROOT_W + 3;
	localparam int CNT_W      = $clog2(ROOT_W + 1);
	localparam int IDX_W      = 2;

	// configuration register index
	localparam logic [IDX_W-1:0] REG_RECUR_COEFF = 2'd0;
	localparam logic [IDX_W-1:0] REG_TONE_COSINE = 2'd1;
	localparam logic [IDX_W-1:0] REG_TONE_SINE   = 2'd2;

	localparam logic [COEF_W-1:0] SINE_RESET = 32'h4000_0000;

	// multiplier operand select
	localparam logic [2:0] SEL_REC = 3'd0;   // s1 * recur_coeff
	localparam logic [2:0] SEL_COS = 3'd1;   // s2 * tone_cosine
	localparam logic [2:0] SEL_SIN = 3'd2;   // s2 * tone_sine
	localparam logic [2:0] SEL_RE  = 3'd3;   // re * re
	localparam logic [2:0] SEL_IM  = 3'd4;   // im * im

	typedef struct packed {
		logic       take_in;     // capture sample word
		logic       mul_start;   // launch a multiply
		logic [2:0] mul_sel;
		logic       mul_keep;    // accumulate onto the previous product
		logic       upd_state;   // write s0 into the state pair
		logic       upd_re;
		logic       upd_im;
		logic       sqrt_start;
		logic       load_out;    // load result register, clear state
	} gtm_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic sqrt_done;
		logic blk_last;
		logic out_free;
	} gtm_stat_t;

endpackage

// ===== src/goertzel_tone_magnitude_core.sv =====
// Top level of the Goertzel single-tone magnitude detector.
// Depends on gtm_pkg, gtm_ctrl, gtm_datapath (which holds gtm_mul and gtm_isqrt).

// Goertzel tone magnitude core. Each sample word runs s0 = x + coeff*s1 - s2
// on Q40.8 state (saturating at 48 bits, products rounded half away from zero
// after the Q.30 shift). A sample with tlast set closes the block: the core
// forms re = s1 - s2*cos and im = s2*sin, takes floor(sqrt(re^2 + im^2)) and
// returns it scaled back to an integer on the master side, with tuser set when
// the value clipped at 2^32 - 1; the state then returns to zero. Each sample
// word goes through the accept/launch step, four slices for the 48x32 product
// on the shared 24x24 multiplier and a state update; no new word is accepted
// before that. A block-end word then adds four further products (cos, sin,
// re^2 and im^2, the squares accumulated together), a bit-per-cycle square
// root and the hand-over of the result. A finished result sits in an output
// register, so the next block starts while it waits; the core stalls only if
// a second result is ready before the first was taken. Coefficient registers
// (0 recur_coeff Q2.30, 1 tone_cosine Q1.30, 2 tone_sine Q1.30, reset values
// 0, 0, 1.0) are written through cfg_we; the user must write them only while
// the core is idle, which the block itself does not enforce; index 3 is
// ignored.
module goertzel_tone_magnitude_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// sample stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [gtm_pkg::SAMPLE_W-1:0]  s_tdata,    // [15:0] sample
	input  logic                          s_tlast,    // block_end
	// magnitude stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [gtm_pkg::MAG_W-1:0]     m_tdata,    // [31:0] magnitude
	output logic                          m_tuser,    // [0] saturated
	// configuration writes
	input  logic                          cfg_we,
	input  logic [gtm_pkg::IDX_W-1:0]     cfg_index,
	input  logic [gtm_pkg::COEF_W-1:0]    cfg_data
);

	gtm_pkg::gtm_cmd_t  cmd;
	gtm_pkg::gtm_stat_t stat;

	// sequencer; accepts a word only in its idle state
	gtm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// arithmetic, state and the output register
	gtm_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.sample    (s_tdata),
		.block_end (s_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.magnitude (m_tdata),
		.saturated (m_tuser)
	);

endmodule

// ===== src/gtm_mul.sv =====
// Sequential 48x48 unsigned multiply-accumulate, one 24x24 slice per cycle.
// Depends on gtm_pkg.
module gtm_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        keep,
	input  logic [gtm_pkg::ACC_W-1:0]   a,
	input  logic [gtm_pkg::ACC_W-1:0]   b,
	output logic [gtm_pkg::PROD_W-1:0]  prod,
	output logic                        done
);

	logic [gtm_pkg::ACC_W-1:0]  a_q, b_q;
	logic [gtm_pkg::PROD_W-1:0] acc_q;
	logic [1:0]                 step_q;
	logic                       busy_q, done_q;
	logic [gtm_pkg::HALF_W-1:0] a_slice, b_slice;
	logic [gtm_pkg::ACC_W-1:0]  pp;
	logic [gtm_pkg::PROD_W-1:0] pp_sh;

	assign a_slice = step_q[1] ? a_q[gtm_pkg::ACC_W-1:gtm_pkg::HALF_W] : a_q[gtm_pkg::HALF_W-1:0];
	assign b_slice = step_q[0] ? b_q[gtm_pkg::ACC_W-1:gtm_pkg::HALF_W] : b_q[gtm_pkg::HALF_W-1:0];
	assign pp      = a_slice * b_slice;

	// weight of the slice pair: 0, 24 or 48 bits
	always_comb begin
		unique case (step_q)
			2'd0:       pp_sh = {{gtm_pkg::ACC_W{1'b0}}, pp};
			2'd1, 2'd2: pp_sh = {{gtm_pkg::HALF_W{1'b0}}, pp, {gtm_pkg::HALF_W{1'b0}}};
			default:    pp_sh = {pp, {gtm_pkg::ACC_W{1'b0}}};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 2'd0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			step_q <= 2'd0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			step_q <= step_q + 2'd1;
			busy_q <= (step_q != 2'd3);
			done_q <= (step_q == 2'd3);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			if (!keep) begin
				acc_q <= '0;
			end
		end else if (busy_q) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	assign prod = acc_q;
	assign done = done_q;

endmodule

// ===== src/gtm_isqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on gtm_pkg.
module gtm_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [gtm_pkg::RAD_W-1:0]   radicand,
	output logic [gtm_pkg::ROOT_W-1:0]  root,
	output logic                        done
);

	logic [gtm_pkg::RAD_W-1:0]  rad_q;
	logic [gtm_pkg::REM_W-1:0]  rem_q;
	logic [gtm_pkg::ROOT_W-1:0] root_q;
	logic [gtm_pkg::CNT_W-1:0]  cnt_q;
	logic                       busy_q, done_q;
	logic [gtm_pkg::REM_W-1:0]  cand, trial;
	logic                       fits;

	// bring down the next two radicand bits, try root*4+1
	assign cand  = {rem_q[gtm_pkg::REM_W-3:0], rad_q[gtm_pkg::RAD_W-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign fits  = (cand >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= gtm_pkg::CNT_W'(gtm_pkg::ROOT_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != gtm_pkg::CNT_W'(1));
			done_q <= (cnt_q == gtm_pkg::CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[gtm_pkg::RAD_W-3:0], 2'b00};
			rem_q  <= fits ? (cand - trial) : cand;
			root_q <= {root_q[gtm_pkg::ROOT_W-2:0], fits};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

// ===== src/gtm_datapath.sv =====
// Datapath: config registers, state pair, rounding/saturation, result register.
// Depends on gtm_pkg, gtm_mul, gtm_isqrt.
module gtm_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gtm_pkg::gtm_cmd_t             cmd,
	output gtm_pkg::gtm_stat_t            stat,
	input  logic [gtm_pkg::SAMPLE_W-1:0]  sample,
	input  logic                          block_end,
	input  logic                          cfg_we,
	input  logic [gtm_pkg::IDX_W-1:0]     cfg_index,
	input  logic [gtm_pkg::COEF_W-1:0]    cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [gtm_pkg::MAG_W-1:0]     magnitude,
	output logic                          saturated
);

	localparam int AW  = gtm_pkg::ACC_W;
	localparam int CW  = gtm_pkg::COEF_W;
	localparam int QW  = AW + CW;          // q30 product bits
	localparam int MW  = QW - gtm_pkg::FRAC_SHIFT;

	function automatic logic [AW-1:0] mag_acc(input logic [AW-1:0] v);
		return v[AW-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [CW-1:0] mag_coef(input logic [CW-1:0] v);
		return v[CW-1] ? (~v + 1'b1) : v;
	endfunction

	// clamp a two-bit-grown value to the signed state range
	function automatic logic [AW-1:0] sat_acc(input logic [AW+1:0] v);
		logic [AW-1:0] r;
		if (v[AW+1:AW-1] == 3'b000 || v[AW+1:AW-1] == 3'b111) begin
			r = v[AW-1:0];
		end else if (v[AW+1]) begin
			r = {1'b1, {(AW-1){1'b0}}};
		end else begin
			r = {1'b0, {(AW-1){1'b1}}};
		end
		return r;
	endfunction

	// magnitude product >> 30, round half away from zero, saturate, apply sign
	function automatic logic [AW-1:0] q30_round(input logic [gtm_pkg::PROD_W-1:0] p,
	                                            input logic neg);
		logic [QW-1:0] t;
		logic [MW-1:0] m;
		logic [MW-1:0] lim;
		t   = p[QW-1:0] + (QW'(1) << (gtm_pkg::FRAC_SHIFT - 1));
		m   = t[QW-1:gtm_pkg::FRAC_SHIFT];
		lim = {{(MW-AW+1){1'b0}}, {(AW-1){1'b1}}} + MW'(neg);
		if (m > lim) begin
			m = lim;
		end
		return neg ? AW'(~m + 1'b1) : m[AW-1:0];
	endfunction

	function automatic logic [AW+1:0] ext2(input logic [AW-1:0] v);
		return {{2{v[AW-1]}}, v};
	endfunction

	logic [CW-1:0]                 coeff_q, cos_q, sin_q;
	logic [AW-1:0]                 s1_q, s2_q, re_q, im_q;
	logic [gtm_pkg::SAMPLE_W-1:0]  x_q;
	logic                          last_q, neg_q, ovf_q;
	logic                          oval_q, osat_q;
	logic [gtm_pkg::MAG_W-1:0]     omag_q;

	logic [AW-1:0]                 op_a, op_b;
	logic                          op_neg;
	logic [gtm_pkg::PROD_W-1:0]    prod;
	logic                          mul_done, sqrt_done;
	logic [gtm_pkg::ROOT_W-1:0]    root;
	logic [AW-1:0]                 x_full, qprod, s0a, s0, re_new;

	always_comb begin
		unique case (cmd.mul_sel)
			gtm_pkg::SEL_REC: begin
				op_a   = mag_acc(s1_q);
				op_b   = AW'(mag_coef(coeff_q));
				op_neg = s1_q[AW-1] ^ coeff_q[CW-1];
			end
			gtm_pkg::SEL_COS: begin
				op_a   = mag_acc(s2_q);
				op_b   = AW'(mag_coef(cos_q));
				op_neg = s2_q[AW-1] ^ cos_q[CW-1];
			end
			gtm_pkg::SEL_SIN: begin
				op_a   = mag_acc(s2_q);
				op_b   = AW'(mag_coef(sin_q));
				op_neg = s2_q[AW-1] ^ sin_q[CW-1];
			end
			gtm_pkg::SEL_RE: begin
				op_a   = mag_acc(re_q);
				op_b   = mag_acc(re_q);
				op_neg = 1'b0;
			end
			gtm_pkg::SEL_IM: begin
				op_a   = mag_acc(im_q);
				op_b   = mag_acc(im_q);
				op_neg = 1'b0;
			end
			default: begin
				op_a   = '0;
				op_b   = '0;
				op_neg = 1'b0;
			end
		endcase
	end

	gtm_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.keep   (cmd.mul_keep),
		.a      (op_a),
		.b      (op_b),
		.prod   (prod),
		.done   (mul_done)
	);

	gtm_isqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (prod[gtm_pkg::RAD_W-1:0]),
		.root     (root),
		.done     (sqrt_done)
	);

	assign x_full = {{(AW-gtm_pkg::SAMPLE_W-gtm_pkg::SAMPLE_FRAC){x_q[gtm_pkg::SAMPLE_W-1]}},
	                 x_q, {gtm_pkg::SAMPLE_FRAC{1'b0}}};
	assign qprod  = q30_round(prod, neg_q);
	assign s0a    = sat_acc(ext2(x_full) + ext2(qprod));
	assign s0     = sat_acc(ext2(s0a) - ext2(s2_q));
	assign re_new = sat_acc(ext2(s1_q) - ext2(qprod));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= '0;
			cos_q   <= '0;
			sin_q   <= gtm_pkg::SINE_RESET;
			s1_q    <= '0;
			s2_q    <= '0;
			last_q  <= 1'b0;
			oval_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					gtm_pkg::REG_RECUR_COEFF: coeff_q <= cfg_data;
					gtm_pkg::REG_TONE_COSINE: cos_q   <= cfg_data;
					gtm_pkg::REG_TONE_SINE:   sin_q   <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.take_in) begin
				last_q <= block_end;
			end
			if (cmd.load_out) begin
				s1_q <= '0;
				s2_q <= '0;
			end else if (cmd.upd_state) begin
				s1_q <= s0;
				s2_q <= s1_q;
			end
			if (cmd.load_out) begin
				oval_q <= 1'b1;
			end else if (out_ready) begin
				oval_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			x_q <= sample;
		end
		if (cmd.mul_start) begin
			neg_q <= op_neg;
		end
		if (cmd.upd_re) begin
			re_q <= re_new;
		end
		if (cmd.upd_im) begin
			im_q <= qprod;
		end
		if (cmd.sqrt_start) begin
			ovf_q <= |prod[gtm_pkg::PROD_W-1:gtm_pkg::RAD_W];
		end
		if (cmd.load_out) begin
			omag_q <= ovf_q ? {gtm_pkg::MAG_W{1'b1}}
			                : root[gtm_pkg::ROOT_W-1:gtm_pkg::ROOT_W-gtm_pkg::MAG_W];
			osat_q <= ovf_q;
		end
	end

	assign stat.mul_done  = mul_done;
	assign stat.sqrt_done = sqrt_done;
	assign stat.blk_last  = last_q;
	assign stat.out_free  = !oval_q || out_ready;

	assign out_valid = oval_q;
	assign magnitude = omag_q;
	assign saturated = osat_q;

endmodule

// ===== src/gtm_ctrl.sv =====
// Sequencer: steps the datapath through recurrence, block-end terms and root.
// Depends on gtm_pkg.
module gtm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  gtm_pkg::gtm_stat_t  stat,
	output gtm_pkg::gtm_cmd_t   cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MREC = 4'd1;   // s1 * coeff
	localparam logic [3:0] ST_LCOS = 4'd2;
	localparam logic [3:0] ST_MCOS = 4'd3;   // s2 * cos
	localparam logic [3:0] ST_MSIN = 4'd4;   // s2 * sin
	localparam logic [3:0] ST_LSQ  = 4'd5;
	localparam logic [3:0] ST_MSQR = 4'd6;   // re^2
	localparam logic [3:0] ST_MSQI = 4'd7;   // + im^2
	localparam logic [3:0] ST_ROOT = 4'd8;
	localparam logic [3:0] ST_OUT  = 4'd9;

	logic [3:0] state_q, state_d;

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_in   = 1'b1;
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = gtm_pkg::SEL_REC;
					state_d       = ST_MREC;
				end
			end
			ST_MREC: begin
				if (stat.mul_done) begin
					cmd.upd_state = 1'b1;
					state_d       = stat.blk_last ? ST_LCOS : ST_IDLE;
				end
			end
			ST_LCOS: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = gtm_pkg::SEL_COS;
				state_d       = ST_MCOS;
			end
			ST_MCOS: begin
				if (stat.mul_done) begin
					cmd.upd_re    = 1'b1;
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = gtm_pkg::SEL_SIN;
					state_d       = ST_MSIN;
				end
			end
			ST_MSIN: begin
				if (stat.mul_done) begin
					cmd.upd_im = 1'b1;
					state_d    = ST_LSQ;
				end
			end
			ST_LSQ: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = gtm_pkg::SEL_RE;
				state_d       = ST_MSQR;
			end
			ST_MSQR: begin
				if (stat.mul_done) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = gtm_pkg::SEL_IM;
					cmd.mul_keep  = 1'b1;
					state_d       = ST_MSQI;
				end
			end
			ST_MSQI: begin
				if (stat.mul_done) begin
					cmd.sqrt_start = 1'b1;
					state_d        = ST_ROOT;
				end
			end
			ST_ROOT: begin
				if (stat.sqrt_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
